// ===== hdl/rsc_pkg.sv =====
// rsc_pkg: shared widths, codes, control structs and colour expansion tables
// for the rgb332 row scaler; no dependencies
package rsc_pkg;

   // line store depth
   localparam int LINE_MAX = 1024;
   localparam int RAM_AW   = $clog2(LINE_MAX);

   // field widths
   localparam int FUNC_W = 1;
   localparam int POS_W  = 12;
   localparam int PIX_W  = 8;
   localparam int CH_W   = 8;
   localparam int MASK_W = 32;
   localparam int FMT_W  = 2;
   localparam int SW_W   = 11;
   localparam int DW_W   = 13;

   // column scaling divider
   localparam int PROD_W = POS_W + SW_W;
   localparam int Q_W    = SW_W;
   localparam int QCNT_W = $clog2(Q_W);
   localparam int IDX_W  = (RAM_AW > Q_W) ? RAM_AW : Q_W;

   // mask lanes
   localparam int SH_W      = $clog2(MASK_W);
   localparam int SH_MAX    = MASK_W - 1;
   localparam int NIB       = 4;
   localparam int CH_MAX    = 255;
   localparam int DIV_STEPS = MASK_W / 2;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   // register file
   localparam int REG_IDX_W = 3;
   localparam int CSR_AW    = REG_IDX_W + 2;
   localparam int CSR_DW    = 32;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_PIXEL_FORMAT,
      REG_RED_MASK,
      REG_GREEN_MASK,
      REG_BLUE_MASK,
      REG_SOURCE_WIDTH,
      REG_DEST_WIDTH
   } reg_idx_type;

   localparam logic [FMT_W-1:0]  FMT_RGB = 2'd0;
   localparam logic [FMT_W-1:0]  FMT_BGR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_EMIT = 1'b1;

   localparam logic [FMT_W-1:0]  FMT_RST   = FMT_RGB;
   localparam logic [MASK_W-1:0] RMASK_RST = 32'h00FF_0000;
   localparam logic [MASK_W-1:0] GMASK_RST = 32'h0000_FF00;
   localparam logic [MASK_W-1:0] BMASK_RST = 32'h0000_00FF;
   localparam logic [SW_W-1:0]   SW_RST    = 11'd1024;
   localparam logic [DW_W-1:0]   DW_RST    = 13'd1024;

   typedef struct packed {
      logic norm_go;
      logic val_go;
   } lane_ctrl_type;

   typedef struct packed {
      logic normed;
      logic done;
   } lane_status_type;

   // x*255/7 truncated
   function automatic logic [CH_W-1:0] exp3(input logic [2:0] x);
      logic [CH_W-1:0] v;
      case (x)
         3'd0:    v = 8'd0;
         3'd1:    v = 8'd36;
         3'd2:    v = 8'd72;
         3'd3:    v = 8'd109;
         3'd4:    v = 8'd145;
         3'd5:    v = 8'd182;
         3'd6:    v = 8'd218;
         default: v = 8'd255;
      endcase
      return v;
   endfunction

   // x*255/3
   function automatic logic [CH_W-1:0] exp2(input logic [1:0] x);
      logic [CH_W-1:0] v;
      case (x)
         2'd0:    v = 8'd0;
         2'd1:    v = 8'd85;
         2'd2:    v = 8'd170;
         default: v = 8'd255;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/rsc_if.sv =====
// rsc_if: request and response channel interfaces of the rgb332 row scaler
// depends on rsc_pkg
interface rsc_req_if;
   import rsc_pkg::*;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [POS_W-1:0]  position;
   logic [PIX_W-1:0]  source_byte;

   modport source (output valid, func, position, source_byte, input ready);
   modport sink   (input valid, func, position, source_byte, output ready);
endinterface

interface rsc_rsp_if;
   import rsc_pkg::*;
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] pixel;
   logic [POS_W-1:0]  column;

   modport source (output valid, pixel, column, input ready);
   modport sink   (input valid, pixel, column, output ready);
endinterface

// ===== hdl/rsc_ram.sv =====
// rsc_ram: generic single write, single read ram with registered read data
// no dependencies
module rsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/rsc_col_div.sv =====
// rsc_col_div: bit-serial restoring divider for column scaling, one quotient bit a cycle
// depends on rsc_pkg
module rsc_col_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rsc_pkg::PROD_W-1:0] dividend,
   input  logic [rsc_pkg::DW_W-1:0]   divisor,
   output logic [rsc_pkg::Q_W-1:0]    quotient,
   output logic                      done
);
   import rsc_pkg::*;

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} div_state_type;

   div_state_type     state_ff, state_in;
   logic [DW_W-1:0]   rem_ff, rem_in;
   logic [Q_W-1:0]    dq_ff, dq_in;
   logic [DW_W-1:0]   dvs_ff, dvs_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   logic [DW_W:0] trial;
   logic [DW_W:0] diff;
   logic          fits;

   // quotient is known to stay below 2^Q_W, so the top bits seed the remainder
   assign trial = {rem_ff, dq_ff[Q_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      if (start) begin
         state_in = D_RUN;
         rem_in   = DW_W'(dividend[PROD_W-1:Q_W]);
         dq_in    = dividend[Q_W-1:0];
         dvs_in   = divisor;
         cnt_in   = '0;
      end else begin
         unique case (state_ff)
            D_RUN: begin
               rem_in = fits ? diff[DW_W-1:0] : trial[DW_W-1:0];
               dq_in  = {dq_ff[Q_W-2:0], fits};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == QCNT_W'(Q_W - 1)) begin
                  state_in = D_DONE;
               end
            end
            D_IDLE, D_DONE: begin
            end
            default: state_in = D_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = dq_ff;
   assign done     = (state_ff == D_DONE);
endmodule

// ===== hdl/rsc_mask_lane.sv =====
// rsc_mask_lane: one colour channel of the mask format; serial mask normalise,
// one multiply, radix-4 serial divide by 255, shift back; depends on rsc_pkg
module rsc_mask_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  rsc_pkg::lane_ctrl_type        ctrl,
   input  logic [rsc_pkg::MASK_W-1:0]    mask,
   input  logic [rsc_pkg::CH_W-1:0]      value,
   output rsc_pkg::lane_status_type      status,
   output logic [rsc_pkg::MASK_W-1:0]    result
);
   import rsc_pkg::*;

   typedef enum logic [2:0] {L_IDLE, L_NORM, L_WAIT, L_MUL, L_DIV, L_DONE} lane_state_type;

   localparam logic [CH_W+1:0] D1 = (CH_W + 2)'(CH_MAX);
   localparam logic [CH_W+1:0] D2 = (CH_W + 2)'(2 * CH_MAX);
   localparam logic [CH_W+1:0] D3 = (CH_W + 2)'(3 * CH_MAX);

   lane_state_type    state_ff, state_in;
   logic [MASK_W-1:0] msk_ff, msk_in;
   logic [MASK_W-1:0] nrm_ff, nrm_in;
   logic [SH_W-1:0]   sh_ff, sh_in;
   logic [CH_W-1:0]   val_ff, val_in;
   logic [MASK_W-1:0] dq_ff, dq_in;
   logic [CH_W-1:0]   rem_ff, rem_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;

   logic [CH_W+MASK_W-1:0] prod_full;
   logic [CH_W+1:0]        trial;

   assign prod_full = (CH_W + MASK_W)'(val_ff) * (CH_W + MASK_W)'(nrm_ff);
   assign trial     = {rem_ff, dq_ff[MASK_W-1 -: 2]};

   always_comb begin
      state_in = state_ff;
      msk_in   = msk_ff;
      nrm_in   = nrm_ff;
      sh_in    = sh_ff;
      val_in   = val_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      if (ctrl.norm_go) begin
         state_in = L_NORM;
         msk_in   = mask;
         nrm_in   = mask;
         sh_in    = '0;
      end else begin
         unique case (state_ff)
            L_NORM: begin
               // whole zero nibbles first, then single bits, capped at bit 31
               if ((nrm_ff[NIB-1:0] == '0) && (sh_ff <= SH_W'(SH_MAX - NIB))) begin
                  nrm_in = nrm_ff >> NIB;
                  sh_in  = sh_ff + SH_W'(NIB);
               end else if (!nrm_ff[0] && (sh_ff != SH_W'(SH_MAX))) begin
                  nrm_in = nrm_ff >> 1;
                  sh_in  = sh_ff + 1'b1;
               end else begin
                  state_in = L_WAIT;
               end
            end
            L_WAIT: begin
               if (ctrl.val_go) begin
                  val_in   = value;
                  state_in = L_MUL;
               end
            end
            L_MUL: begin
               // product kept modulo 2^32
               dq_in    = prod_full[MASK_W-1:0];
               rem_in   = '0;
               cnt_in   = '0;
               state_in = L_DIV;
            end
            L_DIV: begin
               if (trial >= D3) begin
                  rem_in = CH_W'(trial - D3);
                  dq_in  = {dq_ff[MASK_W-3:0], 2'd3};
               end else if (trial >= D2) begin
                  rem_in = CH_W'(trial - D2);
                  dq_in  = {dq_ff[MASK_W-3:0], 2'd2};
               end else if (trial >= D1) begin
                  rem_in = CH_W'(trial - D1);
                  dq_in  = {dq_ff[MASK_W-3:0], 2'd1};
               end else begin
                  rem_in = trial[CH_W-1:0];
                  dq_in  = {dq_ff[MASK_W-3:0], 2'd0};
               end
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
                  state_in = L_DONE;
               end
            end
            L_IDLE, L_DONE: begin
            end
            default: state_in = L_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      msk_ff <= msk_in;
      nrm_ff <= nrm_in;
      sh_ff  <= sh_in;
      val_ff <= val_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   assign result        = (dq_ff << sh_ff) & msk_ff;
   assign status.normed = (state_ff == L_WAIT);
   assign status.done   = (state_ff == L_DONE);
endmodule

// ===== hdl/rgb332_row_scale_convert.sv =====
// rgb332_row_scale_convert: nearest-neighbour row scaler, rgb332 to 32-bit colour
// load transfer: no result, the block stays ready; an emit outside the row is dropped
// emit: 11-step column divider, registered line-store read, then rgb/bgr packing or the
//   16-step lane divide by 255 (mask format); next transfer once the result is registered
// synchronous reset idles the control and restores register defaults; line store not cleared
// depends on rsc_pkg, rsc_if, rsc_ram, rsc_col_div, rsc_mask_lane
module rgb332_row_scale_convert (
   input  logic                         clock,
   input  logic                         reset,
   rsc_req_if.sink                      req_ch,
   rsc_rsp_if.source                    rsp_ch,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [rsc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [rsc_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [rsc_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import rsc_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_DIV, S_READ, S_PICK, S_MASK, S_RESULT} top_state_type;

   // configuration registers
   logic [FMT_W-1:0]  fmt_ff;
   logic [MASK_W-1:0] rmask_ff;
   logic [MASK_W-1:0] gmask_ff;
   logic [MASK_W-1:0] bmask_ff;
   logic [SW_W-1:0]   swidth_ff;
   logic [DW_W-1:0]   dwidth_ff;

   logic        csr_wr;
   reg_idx_type reg_idx;

   // control and result path
   top_state_type     state_ff, state_in;
   logic [POS_W-1:0]  col_ff, col_in;
   logic [MASK_W-1:0] res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic [POS_W-1:0]  rsp_col_ff, rsp_col_in;

   logic req_xfer;
   logic emit_ok;
   logic div_start;
   logic load_we;
   logic out_free;

   logic [PROD_W-1:0] div_dividend;
   logic [Q_W-1:0]    quot;
   logic [IDX_W-1:0]  quot_ext;
   logic              div_done;
   logic              in_range;

   logic [PIX_W-1:0] ram_rdata;
   logic [PIX_W-1:0] px;
   logic [CH_W-1:0]  r8, g8, b8;

   lane_ctrl_type     lane_ctrl;
   lane_status_type   st_r, st_g, st_b;
   logic [MASK_W-1:0] res_r, res_g, res_b;
   logic              lanes_normed;
   logic              lanes_done;

   // ---------------------------------------------------------------- register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = reg_idx_type'(csr_paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_RST;
         rmask_ff  <= RMASK_RST;
         gmask_ff  <= GMASK_RST;
         bmask_ff  <= BMASK_RST;
         swidth_ff <= SW_RST;
         dwidth_ff <= DW_RST;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_PIXEL_FORMAT: fmt_ff    <= csr_pwdata[FMT_W-1:0];
            REG_RED_MASK:     rmask_ff  <= csr_pwdata[MASK_W-1:0];
            REG_GREEN_MASK:   gmask_ff  <= csr_pwdata[MASK_W-1:0];
            REG_BLUE_MASK:    bmask_ff  <= csr_pwdata[MASK_W-1:0];
            REG_SOURCE_WIDTH: swidth_ff <= csr_pwdata[SW_W-1:0];
            REG_DEST_WIDTH:   dwidth_ff <= csr_pwdata[DW_W-1:0];
            default: begin
               // writes past the register list are dropped
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PIXEL_FORMAT: csr_prdata = CSR_DW'(fmt_ff);
         REG_RED_MASK:     csr_prdata = CSR_DW'(rmask_ff);
         REG_GREEN_MASK:   csr_prdata = CSR_DW'(gmask_ff);
         REG_BLUE_MASK:    csr_prdata = CSR_DW'(bmask_ff);
         REG_SOURCE_WIDTH: csr_prdata = CSR_DW'(swidth_ff);
         REG_DEST_WIDTH:   csr_prdata = CSR_DW'(dwidth_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- request side
   // one item in flight; the output register lets the next transfer in while a
   // result is still waiting downstream
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;

   // emits outside the row, or with a zero source width, produce nothing
   assign emit_ok   = (req_ch.func == FUNC_EMIT) &&
                      (DW_W'(req_ch.position) < dwidth_ff) && (swidth_ff != '0);
   assign div_start = req_xfer && emit_ok;

   // loads past the line store are ignored
   assign load_we = req_xfer && (req_ch.func == FUNC_LOAD) &&
                    (int'(req_ch.position) < LINE_MAX);

   // narrow product, then the serial divide by dest_width
   assign div_dividend = PROD_W'(req_ch.position) * PROD_W'(swidth_ff);

   rsc_col_div u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (dwidth_ff),
      .quotient (quot),
      .done     (div_done)
   );

   // ---------------------------------------------------------------- line store
   assign quot_ext = IDX_W'(quot);
   assign in_range = (int'(quot) < LINE_MAX);

   rsc_ram #(
      .WIDTH (PIX_W),
      .DEPTH (LINE_MAX)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (req_ch.position[RAM_AW-1:0]),
      .wr_data (req_ch.source_byte),
      .rd_en   (state_ff == S_READ),
      .rd_addr (quot_ext[RAM_AW-1:0]),
      .rd_data (ram_rdata)
   );

   // an index past the store reads as black; quotient holds until the next emit
   assign px = in_range ? ram_rdata : '0;
   assign r8 = exp3(px[7:5]);
   assign g8 = exp3(px[4:2]);
   assign b8 = exp2(px[1:0]);

   // ---------------------------------------------------------------- mask lanes
   // masks are normalised while the column divider runs
   assign lanes_normed      = st_r.normed && st_g.normed && st_b.normed;
   assign lanes_done        = st_r.done && st_g.done && st_b.done;
   assign lane_ctrl.norm_go = div_start;
   assign lane_ctrl.val_go  = (state_ff == S_PICK) && (fmt_ff != FMT_RGB) &&
                              (fmt_ff != FMT_BGR) && lanes_normed;

   rsc_mask_lane u_lane_r (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .mask   (rmask_ff),
      .value  (r8),
      .status (st_r),
      .result (res_r)
   );

   rsc_mask_lane u_lane_g (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .mask   (gmask_ff),
      .value  (g8),
      .status (st_g),
      .result (res_g)
   );

   rsc_mask_lane u_lane_b (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .mask   (bmask_ff),
      .value  (b8),
      .status (st_b),
      .result (res_b)
   );

   // ---------------------------------------------------------------- sequencer
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_col_in   = rsp_col_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (div_start) begin
               col_in   = req_ch.position;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            // registered ram read
            state_in = S_PICK;
         end
         S_PICK: begin
            case (fmt_ff)
               FMT_RGB: begin
                  res_in   = {8'h00, b8, g8, r8};
                  state_in = S_RESULT;
               end
               FMT_BGR: begin
                  res_in   = {8'h00, r8, g8, b8};
                  state_in = S_RESULT;
               end
               default: begin
                  // mask format, and the unused code that behaves like it
                  if (lanes_normed) begin
                     state_in = S_MASK;
                  end
               end
            endcase
         end
         S_MASK: begin
            if (lanes_done) begin
               res_in   = res_r | res_g | res_b;
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = res_ff;
               rsp_col_in   = col_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff       <= col_in;
      res_ff       <= res_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_col_ff   <= rsp_col_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.pixel  = rsp_pixel_ff;
   assign rsp_ch.column = rsp_col_ff;

   // ---------------------------------------------------------------- checks
   // a result only appears after the sequencer has finished an emit
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESULT))
      else $error("response raised outside the result state");

   // starting the divider clears any stale completion
   a_div_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_done)
      else $error("column divider reports done right after a start");

   // mask normalisation must finish before the pixel is picked
   a_lanes_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PICK) |-> lanes_normed)
      else $error("mask lanes not normalised when the pixel is picked");

endmodule

// ===== tb/tb_rgb332_row_scale_convert.sv =====
// tb_rgb332_row_scale_convert: self-checking testbench of the rgb332 row scaler,
// directed and random load/emit transfers, apb register writes, stall and hold-off
// depends on rsc_pkg, rsc_if and the rgb332_row_scale_convert rtl
module tb_rgb332_row_scale_convert;
   import rsc_pkg::*;

   // format codes without a package name
   localparam logic [FMT_W-1:0] FMT_MASK   = 2'd2;
   localparam logic [FMT_W-1:0] FMT_UNUSED = 2'd3;

   // idle cycles before a register write, covers the mask-format latency
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 130;

   typedef struct packed {
      logic [MASK_W-1:0] pixel;
      logic [POS_W-1:0]  column;
   } pixel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   rsc_req_if req_ch ();
   rsc_rsp_if rsp_ch ();

   rgb332_row_scale_convert dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 unit period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the registers, updated at the access edge of each write
   logic [FMT_W-1:0]  cfg_format     = FMT_RST;
   logic [MASK_W-1:0] cfg_red_mask   = RMASK_RST;
   logic [MASK_W-1:0] cfg_green_mask = GMASK_RST;
   logic [MASK_W-1:0] cfg_blue_mask  = BMASK_RST;
   logic [SW_W-1:0]   cfg_src_width  = SW_RST;
   logic [DW_W-1:0]   cfg_dst_width  = DW_RST;

   // shadow line store; written flags keep emits off never-loaded entries
   logic [PIX_W-1:0] row_copy    [LINE_MAX];
   bit               row_written [LINE_MAX];

   pixel_result_type expected_pixels [$];

   int fail_count   = 0;
   int burst_left   = 0;
   int hold_request = 0;

   // ---------------------------------------------------------------------------
   // colour prediction
   // ---------------------------------------------------------------------------

   // one channel through a mask: scale by the mask span, wrap at 32 bits,
   // divide by 255, then move up to the lowest set bit
   function automatic logic [MASK_W-1:0] mask_lane(input logic [31:0] v,
                                                   input logic [MASK_W-1:0] m);
      int unsigned       s;
      logic [MASK_W-1:0] prod;
      if (m == '0)
         return '0;
      s = 0;
      while (s < 31 && m[s[SH_W-1:0]] == 1'b0)
         s++;
      prod = v * (m >> s);
      prod = prod / 32'd255;
      return (prod << s) & m;
   endfunction

   // scaled column to source byte to packed colour; 0 when the emit gives nothing
   function automatic bit predict_pixel(input logic [POS_W-1:0] col,
                                        output logic [MASK_W-1:0] pix);
      int unsigned      idx;
      logic [PIX_W-1:0] px;
      logic [31:0]      r, g, b;
      pix = '0;
      // column outside the row, or an empty source row
      if (32'(col) >= 32'(cfg_dst_width) || cfg_src_width == '0)
         return 1'b0;
      idx = (32'(col) * 32'(cfg_src_width)) / 32'(cfg_dst_width);
      // an index past the store reads as black
      px = (idx < LINE_MAX) ? row_copy[idx[RAM_AW-1:0]] : '0;
      r = (32'(px[7:5]) * 32'd255) / 32'd7;
      g = (32'(px[4:2]) * 32'd255) / 32'd7;
      b = (32'(px[1:0]) * 32'd255) / 32'd3;
      case (cfg_format)
         FMT_RGB: pix = r | (g << 8) | (b << 16);
         FMT_BGR: pix = b | (g << 8) | (r << 16);
         // the unused code falls into the mask format
         default: pix = mask_lane(r, cfg_red_mask) | mask_lane(g, cfg_green_mask) |
                        mask_lane(b, cfg_blue_mask);
      endcase
      return 1'b1;
   endfunction

   function automatic logic [MASK_W-1:0] pick_mask();
      int unsigned lo, len;
      logic [63:0] span;
      lo   = $urandom_range(0, 31);
      len  = $urandom_range(1, 32 - lo);
      span = ((64'd1 << len) - 64'd1) << lo;
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return MASK_W'(64'd1 << lo);
         3, 4:    return span[MASK_W-1:0];
         default: return MASK_W'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // offers one item in bursts with random gaps; once the transfer is taken
   // the shadow store and the queue of expected pixels are brought up to date
   task automatic send_item(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                            input logic [PIX_W-1:0] byte_in);
      pixel_result_type res;
      int unsigned      gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         // valid only drops when a real gap follows
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.func        <= f;
      req_ch.position    <= p;
      req_ch.source_byte <= byte_in;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (f == FUNC_LOAD) begin
         // a load past the store is dropped by the block
         if (32'(p) < LINE_MAX) begin
            row_copy[p[RAM_AW-1:0]]    = byte_in;
            row_written[p[RAM_AW-1:0]] = 1'b1;
         end
      end else if (predict_pixel(p, res.pixel)) begin
         res.column = p;
         expected_pixels.push_back(res);
      end
   endtask

   // an emit that would read a never-loaded entry gets a load of that entry first
   task automatic emit_column(input logic [POS_W-1:0] col);
      int unsigned idx;
      if (32'(col) < 32'(cfg_dst_width) && cfg_src_width != '0) begin
         idx = (32'(col) * 32'(cfg_src_width)) / 32'(cfg_dst_width);
         if (idx < LINE_MAX && !row_written[idx[RAM_AW-1:0]])
            send_item(FUNC_LOAD, POS_W'(idx), PIX_W'($urandom));
      end
      send_item(FUNC_EMIT, col, PIX_W'($urandom));
   endtask

   // every expected pixel out, then a settle wait for work that gives none
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle, then access until pready
   task automatic write_reg(input reg_idx_type idx, input logic [CSR_DW-1:0] value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_PIXEL_FORMAT: cfg_format     = value[FMT_W-1:0];
         REG_RED_MASK:     cfg_red_mask   = value;
         REG_GREEN_MASK:   cfg_green_mask = value;
         REG_BLUE_MASK:    cfg_blue_mask  = value;
         REG_SOURCE_WIDTH: cfg_src_width  = value[SW_W-1:0];
         REG_DEST_WIDTH:   cfg_dst_width  = value[DW_W-1:0];
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // register defaults: field extremes, load past the store, columns out of row
   task automatic test_reset_defaults();
      send_item(FUNC_LOAD, 12'd0, 8'hFF);
      send_item(FUNC_LOAD, 12'd1023, 8'h00);
      send_item(FUNC_LOAD, 12'd4095, 8'hA5);
      emit_column(12'd0);
      emit_column(12'd1023);
      emit_column(12'd1024);
      emit_column(12'd4095);
   endtask

   // each packing, the unused code, and odd masks: zero, all ones, top bit, gapped
   task automatic test_pack_formats();
      send_item(FUNC_LOAD, 12'd1, 8'h6D);
      emit_column(12'd1);
      write_reg(REG_PIXEL_FORMAT, 32'(FMT_BGR));
      emit_column(12'd1);
      write_reg(REG_PIXEL_FORMAT, 32'(FMT_MASK));
      emit_column(12'd1);
      write_reg(REG_PIXEL_FORMAT, 32'(FMT_UNUSED));
      emit_column(12'd0);
      write_reg(REG_RED_MASK, 32'hFFFF_FFFF);
      write_reg(REG_GREEN_MASK, 32'h8000_0000);
      write_reg(REG_BLUE_MASK, 32'h0000_0000);
      emit_column(12'd0);
      emit_column(12'd1);
      write_reg(REG_RED_MASK, 32'h0F0F_0000);
      write_reg(REG_GREEN_MASK, 32'h0000_0001);
      write_reg(REG_BLUE_MASK, 32'hF000_00F0);
      emit_column(12'd1);
   endtask

   // scaling corners: index past the store, widest row, empty source, empty row
   task automatic test_scale_edges();
      write_reg(REG_PIXEL_FORMAT, 32'(FMT_RGB));
      write_reg(REG_SOURCE_WIDTH, 32'd2047);
      write_reg(REG_DEST_WIDTH, 32'd1000);
      emit_column(12'd999);
      emit_column(12'd0);
      write_reg(REG_SOURCE_WIDTH, 32'd1);
      write_reg(REG_DEST_WIDTH, 32'd8191);
      emit_column(12'd4095);
      write_reg(REG_SOURCE_WIDTH, 32'd0);
      emit_column(12'd5);
      write_reg(REG_SOURCE_WIDTH, 32'd1024);
      write_reg(REG_DEST_WIDTH, 32'd0);
      emit_column(12'd0);
   endtask

   // phases of random settings; mostly in-row emits and in-store loads,
   // the rest loads anywhere and emits at any column
   task automatic test_random_phases();
      int unsigned      sel, row_cols;
      logic [FMT_W-1:0] fmt;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0:       fmt = FMT_RGB;
            1:       fmt = FMT_BGR;
            2:       fmt = FMT_MASK;
            default: fmt = FMT_UNUSED;
         endcase
         write_reg(REG_PIXEL_FORMAT, 32'(fmt));
         write_reg(REG_RED_MASK, pick_mask());
         write_reg(REG_GREEN_MASK, pick_mask());
         write_reg(REG_BLUE_MASK, pick_mask());
         case (phase % 5)
            0:       write_reg(REG_SOURCE_WIDTH, 32'd1);
            1:       write_reg(REG_SOURCE_WIDTH, 32'd1024);
            2:       write_reg(REG_SOURCE_WIDTH, 32'd2047);
            3:       write_reg(REG_SOURCE_WIDTH, $urandom_range(1, 64));
            default: write_reg(REG_SOURCE_WIDTH, $urandom_range(1, 2047));
         endcase
         case (phase % 6)
            0:       write_reg(REG_DEST_WIDTH, 32'd1);
            1:       write_reg(REG_DEST_WIDTH, 32'd4096);
            2:       write_reg(REG_DEST_WIDTH, 32'd8191);
            3:       write_reg(REG_DEST_WIDTH, $urandom_range(1, 64));
            4:       write_reg(REG_DEST_WIDTH, $urandom_range(1, 8191));
            default: write_reg(REG_DEST_WIDTH, 32'd2);
         endcase
         // columns the row can hold, bounded by the position field
         row_cols = (32'(cfg_dst_width) > 4096) ? 4096 : 32'(cfg_dst_width);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
               emit_column(POS_W'($urandom_range(0, row_cols - 1)));
            else if (sel < 85)
               send_item(FUNC_LOAD, POS_W'($urandom_range(0, LINE_MAX - 1)),
                         PIX_W'($urandom));
            else if (sel < 92)
               send_item(FUNC_LOAD, POS_W'($urandom), PIX_W'($urandom));
            else
               emit_column(POS_W'($urandom));
         end
      end
   endtask

   // long hold-off on the result side while emits keep coming, so the
   // block fills and holds off its request side
   task automatic test_backpressure();
      write_reg(REG_PIXEL_FORMAT, 32'(FMT_MASK));
      write_reg(REG_SOURCE_WIDTH, 32'd1024);
      write_reg(REG_DEST_WIDTH, 32'd1024);
      hold_request = 400;
      for (int n = 0; n < 40; n++)
         emit_column(POS_W'($urandom_range(0, 1023)));
   endtask

   // ---------------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------------

   // ready stalls at a rate that changes from epoch to epoch; a hold-off
   // request keeps it low for the asked number of cycles
   initial begin : result_sink
      int unsigned stall_pct, epoch_left, hold_left;
      stall_pct     = 0;
      epoch_left    = 0;
      hold_left     = 0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (epoch_left == 0) begin
            case ($urandom_range(0, 4))
               0, 1:    stall_pct = 0;
               2:       stall_pct = 20;
               3:       stall_pct = 50;
               default: stall_pct = 85;
            endcase
            epoch_left = $urandom_range(20, 80);
         end
         epoch_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // each result transfer against the oldest expected pixel
   always @(posedge clock) begin : check_results
      pixel_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result: column %0d pixel %h", rsp_ch.column, rsp_ch.pixel);
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_ch.pixel !== want.pixel) begin
               $error("pixel: expected %h actual %h", want.pixel, rsp_ch.pixel);
               fail_count++;
            end
            if (rsp_ch.column !== want.column) begin
               $error("column: expected %0d actual %0d", want.column, rsp_ch.column);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // run
   // ---------------------------------------------------------------------------

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_LOAD;
      req_ch.position    = '0;
      req_ch.source_byte = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_pack_formats();
      test_scale_edges();
      test_random_phases();
      test_backpressure();

      wait_idle();
      if (fail_count == 0 && expected_pixels.size() == 0)
         $display("tb_rgb332_row_scale_convert: PASS");
      else
         $display("tb_rgb332_row_scale_convert: FAIL");
      $finish;
   end

   // watchdog, well past the slowest legal run
   initial begin
      #30_000_000;
      $display("tb_rgb332_row_scale_convert: FAIL");
      $finish;
   end

endmodule

// ===== rgb332_row_scale_convert.f =====
hdl/rsc_pkg.sv
hdl/rsc_if.sv
hdl/rsc_ram.sv
hdl/rsc_col_div.sv
hdl/rsc_mask_lane.sv
hdl/rgb332_row_scale_convert.sv
tb/tb_rgb332_row_scale_convert.sv
